// ===== rtl/ema_motion_detector_core_assert.svh =====
`ifndef EMA_MOTION_DETECTOR_CORE_ASSERT_SVH
`define EMA_MOTION_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define EMAMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("emamd: same-cycle check failed");

// Next-cycle implication, off while reset is high
`define EMAMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("emamd: next-cycle check failed");

`endif

// ===== rtl/emamd_pkg.sv =====
`default_nettype none

package emamd_pkg;

  // Item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS      = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] SMOOTHING_GAIN_RST  = 16'd9830;
  localparam logic [15:0] DELTA_THRESHOLD_RST = 16'd7373;
  localparam logic [15:0] LEVEL_THRESHOLD_RST = 16'd13107;
  localparam logic [15:0] HOLD_TICKS_RST      = 16'd200;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } in_item_t;

  typedef struct packed {
    logic               motion_detected;
    logic signed [15:0] average_x;
    logic signed [15:0] average_y;
    logic               indicator_on;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/emamd_filter.sv =====
`default_nettype none

// One axis of the moving average: avg + floor(gain * ((sample << 16) - avg) / 65536)
module emamd_filter (
  input  wire logic        [15:0] gain,
  input  wire logic signed [31:0] avg,
  input  wire logic signed [15:0] sample,
  output logic signed      [31:0] avg_next
);

  logic signed [32:0] sample_q;
  logic signed [32:0] diff;
  logic signed [49:0] product;

  // Distance from the average to the sample, exact in Q17.16
  assign sample_q = {sample[15], sample, 16'b0};
  assign diff     = sample_q - {avg[31], avg};

  // Weighted step; the arithmetic shift floors it
  assign product  = $signed({1'b0, gain}) * diff;
  assign avg_next = avg + product[47:16];

endmodule

`default_nettype wire

// ===== rtl/ema_motion_detector_core.sv =====
`default_nettype none

// Channel   Handshake                     Payload
// sample    sample_valid / sample_stall   sample_item  (emamd_pkg::in_item_t)
// result    result_valid / result_stall   result_item  (emamd_pkg::out_item_t)
// config    cfg_write                     cfg_index, cfg_data
//
// One result per item, one item per cycle while the result is not stalled; an item passes
// from acceptance to result through the input register, then the result register.
// The per-axis multiply-accumulate and the threshold compares sit in the single
// stage between the two registers, so the averages are ready for the next item.
// Reset clears averages and hold counter and restores register defaults.
// A stalled result holds the item register; sample_stall rises only then.

module ema_motion_detector_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   sample_valid,
  output logic                                        sample_stall,
  input  wire emamd_pkg::in_item_t                    sample_item,
  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output emamd_pkg::out_item_t                        result_item,
  input  wire logic                                   cfg_write,
  input  wire logic [emamd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [emamd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [15:0] smoothing_gain;
  logic [15:0] delta_threshold;
  logic [15:0] level_threshold;
  logic [15:0] hold_ticks;

  logic                signed [31:0] filtered_x;
  logic                signed [31:0] filtered_y;
  logic                       [15:0] hold_counter;

  logic                item_valid;
  emamd_pkg::in_item_t item;

  logic advance;
  logic accept;
  logic is_sample;

  logic signed [31:0] filt_x_upd;
  logic signed [31:0] filt_y_upd;
  logic signed [31:0] filtered_x_next;
  logic signed [31:0] filtered_y_next;
  logic        [15:0] hold_counter_next;
  logic signed [15:0] int_x;
  logic signed [15:0] int_y;
  logic        [16:0] dev_x;
  logic        [16:0] mag_x;
  logic        [16:0] mag_y;
  logic               motion;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    logic [16:0] r;
    r = v[16] ? 17'(-v) : 17'(v);
    return r;
  endfunction

  // Handshake
  assign advance      = item_valid && (!result_valid || !result_stall);
  assign sample_stall = item_valid && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;
  assign is_sample    = (item.operation == emamd_pkg::OP_SAMPLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_gain  <= emamd_pkg::SMOOTHING_GAIN_RST;
      delta_threshold <= emamd_pkg::DELTA_THRESHOLD_RST;
      level_threshold <= emamd_pkg::LEVEL_THRESHOLD_RST;
      hold_ticks      <= emamd_pkg::HOLD_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        emamd_pkg::REG_SMOOTHING_GAIN:  smoothing_gain  <= cfg_data;
        emamd_pkg::REG_DELTA_THRESHOLD: delta_threshold <= cfg_data;
        emamd_pkg::REG_LEVEL_THRESHOLD: level_threshold <= cfg_data;
        emamd_pkg::REG_HOLD_TICKS:      hold_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= sample_item;
    end
  end

  // Moving averages, one per axis
  emamd_filter u_filter_x (
    .gain     (smoothing_gain),
    .avg      (filtered_x),
    .sample   (item.accel_x),
    .avg_next (filt_x_upd)
  );

  emamd_filter u_filter_y (
    .gain     (smoothing_gain),
    .avg      (filtered_y),
    .sample   (item.accel_y),
    .avg_next (filt_y_upd)
  );

  assign filtered_x_next = is_sample ? filt_x_upd : filtered_x;
  assign filtered_y_next = is_sample ? filt_y_upd : filtered_y;

  // Detection on the new integer parts
  assign int_x = filtered_x_next[31:16];
  assign int_y = filtered_y_next[31:16];
  assign dev_x = abs17($signed({item.accel_x[15], item.accel_x}) - $signed({int_x[15], int_x}));
  assign mag_x = abs17($signed({int_x[15], int_x}));
  assign mag_y = abs17($signed({int_y[15], int_y}));
  assign motion = is_sample &&
                  ((dev_x > {1'b0, delta_threshold}) ||
                   (mag_x > {1'b0, level_threshold}) ||
                   (mag_y > {1'b0, level_threshold}));

  // Reload on detection, count down on ticks
  always_comb begin
    hold_counter_next = hold_counter;
    if (is_sample) begin
      if (motion) begin
        hold_counter_next = hold_ticks;
      end
    end else if (hold_counter != 16'd0) begin
      hold_counter_next = hold_counter - 16'd1;
    end
  end

  // Commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_x   <= '0;
      filtered_y   <= '0;
      hold_counter <= '0;
    end else if (advance) begin
      filtered_x   <= filtered_x_next;
      filtered_y   <= filtered_y_next;
      hold_counter <= hold_counter_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item.motion_detected <= motion;
      result_item.average_x       <= int_x;
      result_item.average_y       <= int_y;
      result_item.indicator_on    <= (hold_counter_next != 16'd0);
    end
  end

`include "ema_motion_detector_core_assert.svh"

  // A tick never reports motion
  `EMAMD_ASSERT_NEXT(a_tick_quiet, clk, rst, advance && !is_sample, !result_item.motion_detected)

  // A detection lights the indicator exactly when the hold length is nonzero
  `EMAMD_ASSERT_NEXT(a_detect_lights, clk, rst, advance && motion, result_item.indicator_on == ($past(hold_ticks) != 16'd0))

  // The hold counter only grows through a reload
  `EMAMD_ASSERT_NEXT(a_hold_no_grow, clk, rst, !(advance && motion), hold_counter <= $past(hold_counter))

  // Input stalls only behind a full, stalled result register
  `EMAMD_ASSERT_NOW(a_stall_cause, clk, rst, sample_stall, item_valid && result_valid)

endmodule

`default_nettype wire

// ===== dv/ema_motion_detector_core_tb.sv =====
module ema_motion_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int BLOCK_ITEMS     = 225;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              sample_valid = 1'b0;
  logic                              sample_stall;
  emamd_pkg::in_item_t               sample_item  = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  emamd_pkg::out_item_t              result_item;
  logic                              cfg_write    = 1'b0;
  logic [emamd_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [emamd_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

  // Shadow of the detector: registers, averages and hold counter
  logic [15:0]        gain_q16    = emamd_pkg::SMOOTHING_GAIN_RST;
  logic [15:0]        delta_limit = emamd_pkg::DELTA_THRESHOLD_RST;
  logic [15:0]        level_limit = emamd_pkg::LEVEL_THRESHOLD_RST;
  logic [15:0]        hold_reload = emamd_pkg::HOLD_TICKS_RST;
  logic signed [31:0] avg_x = '0;
  logic signed [31:0] avg_y = '0;
  logic [15:0]        hold_count = '0;

  emamd_pkg::out_item_t pending_results[$];
  int                   mismatch_count = 0;
  int                   cycle_count    = 0;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_off_requests = 0;
  int hold_off_served   = 0;
  int stall_left        = 0;

  ema_motion_detector_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Move one Q16.16 average toward a sample: avg + floor(gain * ((sample << 16) - avg) / 65536)
  function automatic logic signed [31:0] ema_step(logic signed [31:0] avg,
                                                  logic signed [15:0] s);
    longint diff;
    longint prod;
    logic signed [63:0] sum;
    diff = (longint'(s) <<< 16) - longint'(avg);
    prod = longint'(gain_q16) * diff;
    sum = longint'(avg) + (prod >>> 16);
    return sum[31:0];
  endfunction

  // Advance the shadow state by one item and return the result it causes
  function automatic emamd_pkg::out_item_t predict_motion_result(emamd_pkg::in_item_t it);
    emamd_pkg::out_item_t r;
    longint ix;
    longint iy;
    r.motion_detected = 1'b0;
    if (it.operation == emamd_pkg::OP_SAMPLE) begin
      avg_x = ema_step(avg_x, it.accel_x);
      avg_y = ema_step(avg_y, it.accel_y);
      ix = longint'($signed(avg_x[31:16]));
      iy = longint'($signed(avg_y[31:16]));
      if (magnitude(longint'(it.accel_x) - ix) > longint'(delta_limit) ||
          magnitude(ix) > longint'(level_limit) ||
          magnitude(iy) > longint'(level_limit)) begin
        r.motion_detected = 1'b1;
        hold_count = hold_reload;
      end
    end else if (hold_count != 16'd0) begin
      hold_count = hold_count - 16'd1;
    end
    r.average_x    = avg_x[31:16];
    r.average_y    = avg_y[31:16];
    r.indicator_on = (hold_count != 16'd0);
    return r;
  endfunction

  // Check each accepted result
  always @(posedge clk) begin
    emamd_pkg::out_item_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: no item outstanding");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_item.motion_detected !== exp_r.motion_detected) begin
          $error("motion_detected: expected %0d, got %0d",
                 exp_r.motion_detected, result_item.motion_detected);
          mismatch_count++;
        end
        if (result_item.average_x !== exp_r.average_x) begin
          $error("average_x: expected %0d, got %0d", exp_r.average_x, result_item.average_x);
          mismatch_count++;
        end
        if (result_item.average_y !== exp_r.average_y) begin
          $error("average_y: expected %0d, got %0d", exp_r.average_y, result_item.average_y);
          mismatch_count++;
        end
        if (result_item.indicator_on !== exp_r.indicator_on) begin
          $error("indicator_on: expected %0d, got %0d",
                 exp_r.indicator_on, result_item.indicator_on);
          mismatch_count++;
        end
      end
    end
  end

  // Hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (hold_off_requests != hold_off_served) begin
      result_stall <= 1'b1;
      stall_left <= HOLD_OFF_CYCLES;
      hold_off_served <= hold_off_requests;
    end else begin
      result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Offer one item until accepted, then idle at random
  task automatic send_item(input emamd_pkg::in_item_t it);
    sample_valid <= 1'b1;
    sample_item  <= it;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_results.push_back(predict_motion_result(it));
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
  endtask

  task automatic send_fields(input logic op, input int x, input int y);
    emamd_pkg::in_item_t it;
    it.operation = op;
    it.accel_x   = 16'(x);
    it.accel_y   = 16'(y);
    send_item(it);
  endtask

  // Stop offering and wait until every outstanding result has arrived
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [emamd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      emamd_pkg::REG_SMOOTHING_GAIN:  gain_q16    = val;
      emamd_pkg::REG_DELTA_THRESHOLD: delta_limit = val;
      emamd_pkg::REG_LEVEL_THRESHOLD: level_limit = val;
      emamd_pkg::REG_HOLD_TICKS:      hold_reload = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] random_accel();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 4000)) - 2000);
      2: return 16'(16384 + int'($urandom_range(0, 6000)) - 3000);
      3: return 16'(-16384 + int'($urandom_range(0, 6000)) - 3000);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic emamd_pkg::in_item_t random_item();
    emamd_pkg::in_item_t it;
    it.operation = ($urandom_range(0, 99) < 35) ? emamd_pkg::OP_TICK : emamd_pkg::OP_SAMPLE;
    it.accel_x   = random_accel();
    it.accel_y   = random_accel();
    return it;
  endfunction

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 2000));
      1: return 16'($urandom_range(2000, 20000));
      2: return 16'($urandom);
      default: return 16'($urandom_range(60000, 65535));
    endcase
  endfunction

  // Reset register values: a quiet sample, then a step that trips the X delta
  task automatic test_defaults();
    send_fields(emamd_pkg::OP_SAMPLE, 0, 0);
    send_fields(emamd_pkg::OP_SAMPLE, 16384, 0);
    send_fields(emamd_pkg::OP_TICK, 0, 0);
  endtask

  // Full gain with the sample fields at their extremes; tick payload ignored
  task automatic test_extremes();
    write_reg(emamd_pkg::REG_SMOOTHING_GAIN, 16'hffff);
    send_fields(emamd_pkg::OP_SAMPLE, 32767, -32768);
    send_fields(emamd_pkg::OP_SAMPLE, -32768, 32767);
    send_fields(emamd_pkg::OP_TICK, -1, -1);
  endtask

  // Detection with zero hold turns the lit indicator off
  task automatic test_zero_hold();
    write_reg(emamd_pkg::REG_HOLD_TICKS, 16'd0);
    write_reg(emamd_pkg::REG_DELTA_THRESHOLD, 16'd0);
    send_fields(emamd_pkg::OP_SAMPLE, 100, -100);
  endtask

  // Ticks with the counter already at zero leave it there
  task automatic test_tick_at_zero();
    send_fields(emamd_pkg::OP_TICK, 32767, 32767);
    send_fields(emamd_pkg::OP_TICK, -32768, 0);
  endtask

  // A second detection reloads the counter instead of adding to it
  task automatic test_repeated_detection();
    write_reg(emamd_pkg::REG_HOLD_TICKS, 16'd3);
    send_fields(emamd_pkg::OP_SAMPLE, 5000, 0);
    send_fields(emamd_pkg::OP_TICK, 0, 0);
    send_fields(emamd_pkg::OP_SAMPLE, -5000, 0);
    repeat (4) send_fields(emamd_pkg::OP_TICK, 0, 0);
  endtask

  // Zero gain freezes the averages; maximal limits never trip, zero level does
  task automatic test_zero_gain();
    write_reg(emamd_pkg::REG_SMOOTHING_GAIN, 16'd0);
    write_reg(emamd_pkg::REG_DELTA_THRESHOLD, 16'hffff);
    write_reg(emamd_pkg::REG_LEVEL_THRESHOLD, 16'hffff);
    send_fields(emamd_pkg::OP_SAMPLE, 32767, 32767);
    send_fields(emamd_pkg::OP_SAMPLE, -32768, -32768);
    write_reg(emamd_pkg::REG_LEVEL_THRESHOLD, 16'd0);
    send_fields(emamd_pkg::OP_SAMPLE, 0, 0);
  endtask

  // Long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    write_reg(emamd_pkg::REG_SMOOTHING_GAIN, 16'd9830);
    write_reg(emamd_pkg::REG_DELTA_THRESHOLD, 16'd7373);
    write_reg(emamd_pkg::REG_LEVEL_THRESHOLD, 16'd13107);
    write_reg(emamd_pkg::REG_HOLD_TICKS, 16'd5);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_requests++;
    repeat (40) send_item(random_item());
  endtask

  // Random items in blocks, each with its own settings and idling pattern
  task automatic test_random_traffic();
    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0: begin
          write_reg(emamd_pkg::REG_SMOOTHING_GAIN, 16'hffff);
          write_reg(emamd_pkg::REG_DELTA_THRESHOLD, 16'd0);
          write_reg(emamd_pkg::REG_LEVEL_THRESHOLD, 16'd0);
          write_reg(emamd_pkg::REG_HOLD_TICKS, 16'($urandom_range(0, 8)));
        end
        5: begin
          write_reg(emamd_pkg::REG_SMOOTHING_GAIN, random_gain());
          write_reg(emamd_pkg::REG_DELTA_THRESHOLD, 16'hffff);
          write_reg(emamd_pkg::REG_LEVEL_THRESHOLD, 16'hffff);
          write_reg(emamd_pkg::REG_HOLD_TICKS, 16'($urandom_range(0, 12)));
        end
        default: begin
          write_reg(emamd_pkg::REG_SMOOTHING_GAIN, random_gain());
          write_reg(emamd_pkg::REG_DELTA_THRESHOLD, 16'($urandom_range(0, 20000)));
          write_reg(emamd_pkg::REG_LEVEL_THRESHOLD, 16'($urandom_range(4000, 40000)));
          write_reg(emamd_pkg::REG_HOLD_TICKS,
                    (blk == 4) ? 16'hffff : 16'($urandom_range(0, 12)));
        end
      endcase
      if (blk < 2) begin
        sender_idle_pct   = 10;
        receiver_idle_pct = 70;
      end else if (blk < 4) begin
        sender_idle_pct   = 70;
        receiver_idle_pct = 10;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      repeat (BLOCK_ITEMS) send_item(random_item());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct   = 10;
    receiver_idle_pct = 70;
    test_defaults();
    test_extremes();
    test_zero_hold();
    test_tick_at_zero();
    test_repeated_detection();
    test_zero_gain();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/emamd_pkg.sv
rtl/emamd_filter.sv
rtl/ema_motion_detector_core.sv
dv/ema_motion_detector_core_tb.sv
